// ===== hdl/qss_pkg.sv =====
package qss_pkg;

  localparam int MAX_ITEMS   = 64;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int SCORE_W     = 16;
  localparam int ENTRY_W     = IDX_W + SCORE_W;
  localparam int RANGE_W     = 2 * IDX_W;
  localparam int STACK_DEPTH = 64;

  // signed index wide enough for hi + 1 and lo - 1
  typedef logic signed [IDX_W+1:0] sidx_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_POP,
    ST_SETUP,
    ST_PIVOT,
    ST_SCAN,
    ST_SWAP1,
    ST_SWAP2,
    ST_PUSH1,
    ST_PUSH2,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_INIT,
    OP_POP,
    OP_SETUP,
    OP_PIVOT,
    OP_SCAN,
    OP_SWAP1,
    OP_SWAP2,
    OP_PUSH1,
    OP_PUSH2,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } qss_cmd_t;

  typedef struct packed {
    logic stk_empty;
    logic scan_done;
    logic do_swap;
    logic more;
    logic skip_push;
    logic emit_last;
  } qss_stat_t;

endpackage

// ===== hdl/qss_ctrl.sv =====
module qss_ctrl import qss_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      last,
  input  qss_stat_t stat,
  output qss_cmd_t  cmd,
  output logic      busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:  if (start && last) state_next = ST_INIT;
      ST_INIT:  state_next = ST_POP;
      ST_POP:   state_next = stat.stk_empty ? ST_EMIT : ST_SETUP;
      ST_SETUP: state_next = ST_PIVOT;
      ST_PIVOT: state_next = ST_SCAN;
      ST_SCAN: begin
        if (stat.scan_done) begin
          state_next = stat.do_swap ? ST_SWAP1 : ST_PUSH1;
        end
      end
      ST_SWAP1: state_next = ST_SWAP2;
      ST_SWAP2: state_next = stat.more ? ST_SCAN : ST_PUSH1;
      ST_PUSH1: state_next = stat.skip_push ? ST_POP : ST_PUSH2;
      ST_PUSH2: state_next = ST_POP;
      ST_EMIT:  if (stat.emit_last) state_next = ST_LOAD;
      default:  state_next = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    cmd.op = OP_IDLE;
    busy   = 1'b1;
    unique case (state)
      ST_LOAD: begin
        busy   = 1'b0;
        cmd.op = start ? OP_LOAD : OP_IDLE;
      end
      ST_INIT:  cmd.op = OP_INIT;
      ST_POP:   cmd.op = OP_POP;
      ST_SETUP: cmd.op = OP_SETUP;
      ST_PIVOT: cmd.op = OP_PIVOT;
      ST_SCAN:  cmd.op = OP_SCAN;
      ST_SWAP1: cmd.op = OP_SWAP1;
      ST_SWAP2: cmd.op = OP_SWAP2;
      ST_PUSH1: cmd.op = stat.skip_push ? OP_IDLE : OP_PUSH1;
      ST_PUSH2: cmd.op = OP_PUSH2;
      ST_EMIT:  cmd.op = OP_EMIT;
      default:  cmd.op = OP_IDLE;
    endcase
  end

endmodule

// ===== hdl/qss_dp.sv =====
module qss_dp import qss_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  qss_cmd_t                  cmd,
  input  logic signed [SCORE_W-1:0] score,
  output qss_stat_t                 stat,
  output logic                      valid,
  output logic [IDX_W-1:0]          position,
  output logic signed [SCORE_W-1:0] score_out,
  output logic                      final_res
);

  localparam sidx_t ONE = sidx_t'(1);

  logic [ENTRY_W-1:0] item_mem  [MAX_ITEMS];
  logic [RANGE_W-1:0] stack_mem [STACK_DEPTH];

  logic [ENTRY_W-1:0] rd_a, rd_b, sa, sb;
  logic [RANGE_W-1:0] stk_rd;

  logic [CNT_W-1:0] count, count_next, sp, sp_next, k, k_next, cnt_m1;
  logic [IDX_W-1:0] lo, hi, lo_next, hi_next, mid;
  sidx_t            i, j, i_next, j_next, lo_s, hi_s, i_m1;
  logic signed [SCORE_W-1:0] pv, s_a, s_b;

  logic adv_i, adv_j, push_ok;
  logic [IDX_W-1:0] addr_a, addr_b;

  logic               wr_en, stk_wr_en;
  logic [IDX_W-1:0]   wr_addr, stk_wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [RANGE_W-1:0] stk_wr_data;

  assign s_a    = rd_a[SCORE_W-1:0];
  assign s_b    = rd_b[SCORE_W-1:0];
  assign lo_s   = {2'b00, lo};
  assign hi_s   = {2'b00, hi};
  assign i_m1   = i - ONE;
  assign cnt_m1 = count - CNT_W'(1);

  assign adv_i   = (i <= hi_s) && (s_a < pv);
  assign adv_j   = (j >= lo_s) && (s_b > pv);
  assign push_ok = sp < CNT_W'(STACK_DEPTH);

  assign stat.stk_empty = (sp == '0);
  assign stat.scan_done = !adv_i && !adv_j;
  assign stat.do_swap   = (i <= j);
  assign stat.more      = ((i + ONE) <= (j - ONE));
  assign stat.skip_push = (i_m1 >= hi_s) || (i <= lo_s);
  assign stat.emit_last = (k == cnt_m1);

  // next values of the index registers
  always_comb begin
    count_next = count;
    sp_next    = sp;
    k_next     = k;
    lo_next    = lo;
    hi_next    = hi;
    i_next     = i;
    j_next     = j;
    unique case (cmd.op)
      OP_LOAD: begin
        if (count < CNT_W'(MAX_ITEMS)) count_next = count + CNT_W'(1);
      end
      OP_INIT: begin
        sp_next = (count > CNT_W'(1)) ? CNT_W'(1) : '0;
        k_next  = '0;
      end
      OP_POP: begin
        if (sp != '0) sp_next = sp - CNT_W'(1);
        k_next = '0;
      end
      OP_SETUP: begin
        lo_next = stk_rd[RANGE_W-1:IDX_W];
        hi_next = stk_rd[IDX_W-1:0];
        i_next  = {2'b00, stk_rd[RANGE_W-1:IDX_W]};
        j_next  = {2'b00, stk_rd[IDX_W-1:0]};
      end
      OP_SCAN: begin
        if (adv_i) i_next = i + ONE;
        if (adv_j) j_next = j - ONE;
      end
      OP_SWAP2: begin
        i_next = i + ONE;
        j_next = j - ONE;
      end
      OP_PUSH1: begin
        if ((i < hi_s) && push_ok) sp_next = sp + CNT_W'(1);
      end
      OP_PUSH2: begin
        if ((lo_s < i_m1) && push_ok) sp_next = sp + CNT_W'(1);
      end
      OP_EMIT: begin
        k_next = k + CNT_W'(1);
        if (stat.emit_last) count_next = '0;
      end
      default: ;
    endcase
  end

  assign mid = lo_next + ((hi_next - lo_next) >> 1);

  // read addresses follow the next index values; the emit pass reads at k
  always_comb begin
    priority case (cmd.op)
      OP_SETUP: addr_a = mid;
      OP_EMIT:  addr_a = k[IDX_W-1:0];
      default:  addr_a = i_next[IDX_W-1:0];
    endcase
    addr_b = j_next[IDX_W-1:0];
  end

  // single write port of the item store
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = i[IDX_W-1:0];
    wr_data = sb;
    unique case (cmd.op)
      OP_LOAD: begin
        wr_en   = count < CNT_W'(MAX_ITEMS);
        wr_addr = count[IDX_W-1:0];
        wr_data = {count[IDX_W-1:0], score};
      end
      OP_SWAP1: begin
        wr_en   = 1'b1;
        wr_addr = i[IDX_W-1:0];
        wr_data = sb;
      end
      OP_SWAP2: begin
        wr_en   = 1'b1;
        wr_addr = j[IDX_W-1:0];
        wr_data = sa;
      end
      default: ;
    endcase
  end

  // single write port of the range stack
  always_comb begin
    stk_wr_en   = 1'b0;
    stk_wr_addr = sp[IDX_W-1:0];
    stk_wr_data = {i[IDX_W-1:0], hi};
    unique case (cmd.op)
      OP_INIT: begin
        stk_wr_en   = count > CNT_W'(1);
        stk_wr_addr = '0;
        stk_wr_data = {IDX_W'(0), cnt_m1[IDX_W-1:0]};
      end
      OP_PUSH1: begin
        stk_wr_en   = (i < hi_s) && push_ok;
        stk_wr_data = {i[IDX_W-1:0], hi};
      end
      OP_PUSH2: begin
        stk_wr_en   = (lo_s < i_m1) && push_ok;
        stk_wr_data = {lo, i_m1[IDX_W-1:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) item_mem[wr_addr] <= wr_data;
    rd_a <= item_mem[addr_a];
    rd_b <= item_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (stk_wr_en) stack_mem[stk_wr_addr] <= stk_wr_data;
    stk_rd <= stack_mem[sp_next[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    lo <= lo_next;
    hi <= hi_next;
    i  <= i_next;
    j  <= j_next;
    if (cmd.op == OP_PIVOT) pv <= s_a;
    if (cmd.op == OP_SCAN) begin
      sa <= rd_a;
      sb <= rd_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      sp        <= '0;
      k         <= '0;
      valid     <= 1'b0;
      final_res <= 1'b0;
    end else begin
      count     <= count_next;
      sp        <= sp_next;
      k         <= k_next;
      valid     <= (cmd.op == OP_EMIT);
      final_res <= (cmd.op == OP_EMIT) && stat.emit_last;
    end
  end

  assign position  = rd_a[ENTRY_W-1:SCORE_W];
  assign score_out = rd_a[SCORE_W-1:0];

`ifndef SYNTH
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= CNT_W'(MAX_ITEMS / 2))
    else $error("range stack deeper than half the store");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ITEMS))
    else $error("item count beyond store depth");

  a_scan_window: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_SCAN) |-> ((i <= hi_s + ONE) && (j >= lo_s - ONE)))
    else $error("partition index left its range");

  a_final_ends: assert property (@(posedge clk) disable iff (rst)
    final_res |=> !valid)
    else $error("result word after the final one");
`endif

endmodule

// ===== hdl/quicksort_score_sorter.sv =====
// Score sorter: collects signed scores and returns them in ascending order.
//
// Input: pulse start with score and last while busy is low; one word is taken
// per cycle. Each word is stored with its load position (0, 1, 2, ...). Words
// past MAX_ITEMS are dropped, but their last bit still counts. The word with
// last set closes the set, raises busy and starts the sort.
// Sort: quicksort with a middle pivot and a Hoare-style partition, driven by
// a range stack. Each range passes through pop, setup and pivot fetch, then
// scan steps (both indices move together), swaps and up to two pushes;
// each swap writes its items in turn through the single write port of the
// item store.
// Output: after the sort one word per cycle, each flagged by valid for
// exactly one cycle, with position, score_out and final_res on the last.
// The first result shows in the cycle after emit starts; busy drops on
// the cycle that carries the final result, so the next set may begin there.
// The receiver cannot stall: every result is taken in the cycle it shows.
// Reset (rst, synchronous): empties the set and returns to loading; stored
// scores are not cleared and are never read before they are rewritten.
module quicksort_score_sorter import qss_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [SCORE_W-1:0] score,
  input  logic                      last,
  output logic                      busy,
  output logic                      valid,
  output logic [IDX_W-1:0]          position,
  output logic signed [SCORE_W-1:0] score_out,
  output logic                      final_res
);

  qss_cmd_t  cmd;
  qss_stat_t stat;

  // sequencer: loading, partition steps, range stack handling, emit pass
  qss_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .last  (last),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // item store, range stack, indices and result registers
  qss_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .score     (score),
    .stat      (stat),
    .valid     (valid),
    .position  (position),
    .score_out (score_out),
    .final_res (final_res)
  );

endmodule
